// ----- rtl/core/ttrc_pkg.sv -----
package ttrc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SUM_W  = 16;

    // position multipliers, kept mod 256
    localparam logic [BYTE_W-1:0] ALPHA_MUL = 8'd17;
    localparam logic [BYTE_W-1:0] BETA_MUL  = 8'd31;

    // bias applied to the first byte of a message
    localparam logic [SUM_W-1:0] START_BIAS = 16'd7;

    localparam logic [SUM_W-1:0] FOLD_MOD = 16'hFFFF;

    // widths of the products and of the biased difference
    localparam int unsigned POS_W  = BYTE_W + 1 + SUM_W;
    localparam int unsigned NEG_W  = BYTE_W + SUM_W;
    localparam int unsigned DIFF_W = POS_W + 1;

    // multiple of the modulus that keeps the difference non-negative
    localparam logic [DIFF_W-1:0] DIFF_OFFSET = 26'd16776960;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [SUM_W-1:0]  t_sum;

endpackage

// ----- rtl/core/ttrc_in_if.sv -----
interface ttrc_in_if;
    import ttrc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  start_of_message;

    modport source (output valid, output data_byte, output start_of_message, input ready);
    modport sink   (input valid, input data_byte, input start_of_message, output ready);
endinterface

// ----- rtl/core/ttrc_out_if.sv -----
interface ttrc_out_if;
    import ttrc_pkg::*;

    logic valid;
    logic ready;
    t_sum checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

// ----- rtl/core/three_term_recurrence_checksum_top.sv -----
// Running three-term recurrence checksum over a byte stream. Every input beat
// carries one message byte and a start-of-message flag and yields exactly one
// output beat with the checksum of the message so far. A start byte restarts
// the recurrence (older term 1, newer term byte+7); every later byte at
// position i (mod 256) gives ((byte + (17i mod 256)) * newer - (31i mod 256) * older)
// mod 65535, with a negative difference treated as a 64-bit unsigned wrap.
// Bytes seen before the first start flag continue an implied message with
// both terms 1.
// A beat is registered at the input, the recurrence is evaluated from that
// register and the stored terms, and the checksum is held in an output
// register. Throughput is one byte per clock while the output is accepted;
// a stalled output holds the input register. The rate is set by the term
// registers, which close a 9x16 and an 8x16 multiply in parallel, a subtract
// and a mod-65535 fold per cycle.
module three_term_recurrence_checksum_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttrc_in_if.sink     i_in,
    ttrc_out_if.source  o_out
);
    import ttrc_pkg::*;

    // input stage
    logic  r_in_vld;
    t_byte r_in_byte;
    logic  r_in_som;

    // recurrence state
    t_sum  r_older, n_older;
    t_sum  r_newer, n_newer;
    t_byte r_idx,   n_idx;

    // output stage
    logic  r_out_vld;
    t_sum  r_out_sum;

    logic  w_adv;
    logic  w_in_rdy;

    // datapath
    t_byte              w_alpha;
    t_byte              w_beta;
    logic [BYTE_W:0]    w_coef;
    logic [POS_W-1:0]   w_pos;
    logic [NEG_W-1:0]   w_neg;
    logic               w_borrow;
    logic [DIFF_W-1:0]  w_diff;
    logic [SUM_W:0]     w_fold;
    t_sum               w_step;
    t_sum               w_result;

    // the compute stage moves when the output register is free or draining
    assign w_adv    = r_in_vld && (!r_out_vld || o_out.ready);
    assign w_in_rdy = !r_in_vld || w_adv;

    assign i_in.ready     = w_in_rdy;
    assign o_out.valid    = r_out_vld;
    assign o_out.checksum = r_out_sum;

    always_comb begin
        // position weights, mod 256 by truncation
        w_alpha = t_byte'(r_idx * ALPHA_MUL);
        w_beta  = t_byte'(r_idx * BETA_MUL);

        w_coef = {1'b0, r_in_byte} + {1'b0, w_alpha};
        w_pos  = POS_W'(w_coef) * POS_W'(r_newer);
        w_neg  = NEG_W'(w_beta) * NEG_W'(r_older);

        // 2^64 is 1 mod 65535, so a wrapped difference gains one
        w_borrow = ({1'b0, w_neg} > w_pos);
        w_diff   = {1'b0, w_pos} + DIFF_OFFSET + DIFF_W'(w_borrow) - DIFF_W'(w_neg);

        // 2^16 is 1 mod 65535: add high and low halves, then one correction
        w_fold = {1'b0, w_diff[SUM_W-1:0]} + (SUM_W+1)'(w_diff[DIFF_W-1:SUM_W]);
        if (w_fold >= {1'b0, FOLD_MOD}) begin
            w_step = t_sum'(w_fold - {1'b0, FOLD_MOD});
        end else begin
            w_step = w_fold[SUM_W-1:0];
        end

        if (r_in_som) begin
            w_result = t_sum'(r_in_byte) + START_BIAS;
        end else begin
            w_result = w_step;
        end

        n_older = r_older;
        n_newer = r_newer;
        n_idx   = r_idx;
        if (w_adv) begin
            n_newer = w_result;
            if (r_in_som) begin
                n_older = t_sum'(1);
                n_idx   = t_byte'(1);
            end else begin
                n_older = r_newer;
                n_idx   = r_idx + t_byte'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_older   <= t_sum'(1);
            r_newer   <= t_sum'(1);
            r_idx     <= t_byte'(1);
        end else begin
            if (w_in_rdy) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            r_older <= n_older;
            r_newer <= n_newer;
            r_idx   <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_rdy && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_som  <= i_in.start_of_message;
        end
        if (w_adv) begin
            r_out_sum <= w_result;
        end
    end

    // the held checksum is always the newest term
    a_out_is_newer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_sum == r_newer))
        else $error("output checksum differs from newer term");

    // the modulus itself never appears as a result
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_sum != FOLD_MOD))
        else $error("checksum not fully reduced");

    // terms shift on a continuing byte
    a_term_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_som) |=> (r_older == $past(r_newer)))
        else $error("older term did not take the newer term");

    // a start byte restarts the position count
    a_start_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_som) |=> (r_idx == t_byte'(1) && r_older == t_sum'(1)))
        else $error("start byte did not restart the recurrence");

endmodule
